// File: rtl/dlr_pkg.sv
// Shared constants, state encoding and control bundles of the DDA line rasterizer.
`default_nettype none

package dlr_pkg;

  localparam int CoordBitsDef = 12;
  localparam int FracBitsDef  = 10;
  localparam int ColorBits    = 32;

  // Item kind on the input tuser bit
  localparam logic OpStart = 1'b0;
  localparam logic OpStep  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACTIVE,
    ST_DIV,
    ST_FINISH
  } dlr_state_e;

  // Controller -> datapath
  typedef struct packed {
    logic load;       // start item accepted: set up line, emit first pixel
    logic step;       // step item accepted while a line is active
    logic div_step;   // one slope division iteration
    logic div_first;  // first iteration: compare without shifting
    logic finish;     // write minor step, advance past first pixel
  } dlr_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic pl_zero;    // no pixels left
    logic pl_one;     // next step emits the final pixel
  } dlr_sts_t;

endpackage

`default_nettype wire

// File: rtl/dlr_ctrl.sv
// Controller of the DDA line rasterizer: handshake, divider sequencing, line state.
`default_nettype none

module dlr_ctrl
  import dlr_pkg::*;
#(
  parameter int FRAC_BITS = FracBitsDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_op_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  dlr_sts_t sts_i,
  output dlr_cmd_t cmd_o
);

  localparam int CntW = $clog2(FRAC_BITS + 1);
  localparam logic [CntW-1:0] CntTop = CntW'(FRAC_BITS);

  dlr_state_e state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic out_valid_q, out_valid_d;
  logic out_free, accept;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = ((state_q == ST_IDLE) || (state_q == ST_ACTIVE)) && out_free;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE, ST_ACTIVE: begin
        if (accept && (in_op_i == OpStart)) begin
          cmd_o.load = 1'b1;
          cnt_d      = CntTop;
          state_d    = ST_DIV;
        end else if (accept && (state_q == ST_ACTIVE)) begin
          cmd_o.step = 1'b1;
          if (sts_i.pl_one) begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_DIV: begin
        cmd_o.div_step  = 1'b1;
        cmd_o.div_first = (cnt_q == CntTop);
        if (cnt_q == '0) begin
          state_d = ST_FINISH;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      ST_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d      = sts_i.pl_zero ? ST_IDLE : ST_ACTIVE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.load || cmd_o.step) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/dlr_datapath.sv
// Datapath of the DDA line rasterizer: setup, serial slope divider, accumulators, output register.
`default_nettype none

module dlr_datapath
  import dlr_pkg::*;
#(
  parameter int COORD_BITS = CoordBitsDef,
  parameter int FRAC_BITS  = FracBitsDef
) (
  input  logic                         clk_i,
  input  dlr_cmd_t                     cmd_i,
  input  logic signed [COORD_BITS-1:0] start_x_i,
  input  logic signed [COORD_BITS-1:0] start_y_i,
  input  logic signed [COORD_BITS-1:0] end_x_i,
  input  logic signed [COORD_BITS-1:0] end_y_i,
  input  logic        [ColorBits-1:0]  color_i,
  output logic signed [COORD_BITS-1:0] pixel_x_o,
  output logic signed [COORD_BITS-1:0] pixel_y_o,
  output logic        [ColorBits-1:0]  out_color_o,
  output logic                         last_pixel_o,
  output dlr_sts_t                     sts_o
);

  localparam int AccW  = COORD_BITS + FRAC_BITS + 1;
  localparam int StepW = FRAC_BITS + 2;
  localparam int LenW  = COORD_BITS + 1;
  localparam logic [StepW-1:0] StepOne    = StepW'(1) << FRAC_BITS;
  localparam logic [StepW-1:0] StepNegOne = ~StepOne + 1'b1;

  // Line state
  logic [AccW-1:0]     x_acc_q, x_acc_d, y_acc_q, y_acc_d;
  logic [StepW-1:0]    x_step_q, x_step_d, y_step_q, y_step_d;
  logic [LenW-1:0]     pl_q, pl_d;
  logic [ColorBits-1:0] color_q;
  // Divider state
  logic [LenW-1:0]     len_q, rem_q, rem_d;
  logic [FRAC_BITS:0]  quo_q, quo_d;
  logic                minor_neg_q, x_major_q;
  // Output register
  logic [COORD_BITS-1:0] px_q, py_q, px_d, py_d;
  logic                  last_q, last_d;

  // Setup
  logic [LenW-1:0] dx, dy, adx, ady, major_abs, minor_abs;
  logic            x_major, minor_neg;

  assign dx        = {end_x_i[COORD_BITS-1], end_x_i} - {start_x_i[COORD_BITS-1], start_x_i};
  assign dy        = {end_y_i[COORD_BITS-1], end_y_i} - {start_y_i[COORD_BITS-1], start_y_i};
  assign adx       = dx[LenW-1] ? (~dx + 1'b1) : dx;
  assign ady       = dy[LenW-1] ? (~dy + 1'b1) : dy;
  assign x_major   = (adx >= ady);
  assign major_abs = x_major ? adx : ady;
  assign minor_abs = x_major ? ady : adx;
  assign minor_neg = x_major ? dy[LenW-1] : dx[LenW-1];

  // Divider iteration: |minor| + 1 <= len, so the quotient fits FRAC_BITS + 1 bits
  logic [LenW-1:0] rem_sh;
  logic            ge;
  assign rem_sh = cmd_i.div_first ? rem_q : {rem_q[LenW-2:0], 1'b0};
  assign ge     = (rem_sh >= len_q);

  // Minor step with sign, and the step actually added this cycle
  logic [StepW-1:0] quo_ext, minor_step, x_add, y_add;
  assign quo_ext    = {1'b0, quo_q};
  assign minor_step = minor_neg_q ? (~quo_ext + 1'b1) : quo_ext;
  assign x_add = (cmd_i.finish && !x_major_q) ? minor_step : x_step_q;
  assign y_add = (cmd_i.finish &&  x_major_q) ? minor_step : y_step_q;

  always_comb begin
    x_acc_d  = x_acc_q;
    y_acc_d  = y_acc_q;
    x_step_d = x_step_q;
    y_step_d = y_step_q;
    pl_d     = pl_q;
    rem_d    = rem_q;
    quo_d    = quo_q;
    px_d     = px_q;
    py_d     = py_q;
    last_d   = last_q;
    if (cmd_i.load) begin
      x_acc_d = {start_x_i[COORD_BITS-1], start_x_i, {FRAC_BITS{1'b0}}};
      y_acc_d = {start_y_i[COORD_BITS-1], start_y_i, {FRAC_BITS{1'b0}}};
      if (x_major) begin
        x_step_d = dx[LenW-1] ? StepNegOne : StepOne;
      end else begin
        y_step_d = dy[LenW-1] ? StepNegOne : StepOne;
      end
      pl_d   = major_abs;
      rem_d  = minor_abs + 1'b1;
      quo_d  = '0;
      px_d   = start_x_i;
      py_d   = start_y_i;
      last_d = (major_abs == '0);
    end
    if (cmd_i.div_step) begin
      rem_d = ge ? (rem_sh - len_q) : rem_sh;
      quo_d = {quo_q[FRAC_BITS-1:0], ge};
    end
    if (cmd_i.step) begin
      px_d   = x_acc_q[FRAC_BITS +: COORD_BITS];
      py_d   = y_acc_q[FRAC_BITS +: COORD_BITS];
      last_d = (pl_q == LenW'(1));
      pl_d   = pl_q - 1'b1;
    end
    if (cmd_i.finish) begin
      x_step_d = x_add;
      y_step_d = y_add;
    end
    if (cmd_i.step || cmd_i.finish) begin
      x_acc_d = x_acc_q + {{(AccW-StepW){x_add[StepW-1]}}, x_add};
      y_acc_d = y_acc_q + {{(AccW-StepW){y_add[StepW-1]}}, y_add};
    end
  end

  always_ff @(posedge clk_i) begin
    x_acc_q  <= x_acc_d;
    y_acc_q  <= y_acc_d;
    x_step_q <= x_step_d;
    y_step_q <= y_step_d;
    pl_q     <= pl_d;
    rem_q    <= rem_d;
    quo_q    <= quo_d;
    px_q     <= px_d;
    py_q     <= py_d;
    last_q   <= last_d;
    if (cmd_i.load) begin
      color_q     <= color_i;
      len_q       <= major_abs + 1'b1;
      minor_neg_q <= minor_neg;
      x_major_q   <= x_major;
    end
  end

  assign pixel_x_o    = px_q;
  assign pixel_y_o    = py_q;
  assign out_color_o  = color_q;
  assign last_pixel_o = last_q;
  assign sts_o.pl_zero = (pl_q == '0);
  assign sts_o.pl_one  = (pl_q == LenW'(1));

endmodule

`default_nettype wire

// File: rtl/dda_line_rasterizer.sv
// Top level of the fixed-point DDA line rasterizer.
// Start item: first pixel is registered out in the cycle after acceptance; the input then stalls
//   during the FRAC_BITS + 1 divider iterations and the finish step.
// Step item: one pixel per cycle while the output is taken, set by the accumulator add.
// A step while idle is accepted and yields nothing. A start restarts any running line.
// Reset (rst_ni low, asynchronous) returns to idle with no output pending.
`default_nettype none

module dda_line_rasterizer
  import dlr_pkg::*;
#(
  parameter int COORD_BITS = CoordBitsDef,
  parameter int FRAC_BITS  = FracBitsDef,
  localparam int SDataW = ((4 * COORD_BITS + ColorBits + 7) / 8) * 8,
  localparam int MDataW = ((2 * COORD_BITS + ColorBits + 7) / 8) * 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // Input items
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [SDataW-1:0] s_axis_tdata,  // start_x, start_y, end_x, end_y, pixel_color
  input  logic              s_axis_tuser,  // op: 0 start line, 1 step
  // Result items
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [MDataW-1:0] m_axis_tdata,  // pixel_x, pixel_y, out_color
  output logic              m_axis_tlast   // last_pixel
);

  dlr_cmd_t cmd;
  dlr_sts_t sts;

  logic signed [COORD_BITS-1:0] start_x, start_y, end_x, end_y;
  logic        [ColorBits-1:0]  pixel_color;
  logic signed [COORD_BITS-1:0] pixel_x, pixel_y;
  logic        [ColorBits-1:0]  out_color;

  // Unpack input item, lowest field first
  assign start_x     = s_axis_tdata[0 +: COORD_BITS];
  assign start_y     = s_axis_tdata[COORD_BITS +: COORD_BITS];
  assign end_x       = s_axis_tdata[2*COORD_BITS +: COORD_BITS];
  assign end_y       = s_axis_tdata[3*COORD_BITS +: COORD_BITS];
  assign pixel_color = s_axis_tdata[4*COORD_BITS +: ColorBits];

  // Controller: accepts items only in idle/active with the output register free,
  // then sequences the slope division after a start.
  dlr_ctrl #(
    .FRAC_BITS (FRAC_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_op_i     (s_axis_tuser),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Datapath: setup arithmetic, restoring divider, accumulators and output register.
  dlr_datapath #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .cmd_i        (cmd),
    .start_x_i    (start_x),
    .start_y_i    (start_y),
    .end_x_i      (end_x),
    .end_y_i      (end_y),
    .color_i      (pixel_color),
    .pixel_x_o    (pixel_x),
    .pixel_y_o    (pixel_y),
    .out_color_o  (out_color),
    .last_pixel_o (m_axis_tlast),
    .sts_o        (sts)
  );

  // Pack result item, zero padded to whole bytes
  assign m_axis_tdata = MDataW'({out_color, pixel_y, pixel_x});

endmodule

`default_nettype wire
